### src/h2r_pkg.sv
// ----------------------------------------------------------------------------
// h2r_pkg
// Shared types and codes for the hsv to rgb converter: the hue sector.
// ----------------------------------------------------------------------------
package h2r_pkg;

  localparam int unsigned SECTOR_W = 3;

  typedef logic [SECTOR_W-1:0] sector_t;

  // hue sectors of 60 degrees each
  localparam sector_t SECTOR_RED_YELLOW     = 3'd0;
  localparam sector_t SECTOR_YELLOW_GREEN   = 3'd1;
  localparam sector_t SECTOR_GREEN_CYAN     = 3'd2;
  localparam sector_t SECTOR_CYAN_BLUE      = 3'd3;
  localparam sector_t SECTOR_BLUE_MAGENTA   = 3'd4;
  localparam sector_t SECTOR_MAGENTA_RED    = 3'd5;

endpackage

### src/hsv_to_rgb_converter.sv
// ----------------------------------------------------------------------------
// hsv_to_rgb_converter
// Converts hue, saturation and value into red, green and blue components.
// ----------------------------------------------------------------------------
//
//   channel   handshake       payload
//   --------  --------------  ---------------------------------------------
//   input     push / full     hue_i, saturation_i, brightness_i
//   result    pop / empty     red_o, green_o, blue_o
//
// one item per clock sustained while results are taken; an accepted item
// passes the decoupling queue, the four-stage multiply/divide pipeline in
// the back part and the result queue before it is visible as a result
// reset clears queue pointers and pipeline valid bits, no clearing pass
// a stalled result side holds the pipeline; the input side keeps taking
// items until the decoupling queue fills
//
module hsv_to_rgb_converter #(
  parameter int unsigned CHANNEL_BITS = 8,
  parameter int unsigned HUE_BITS     = 16,
  parameter int unsigned MID_DEPTH    = 4,
  parameter int unsigned OUT_DEPTH    = 2
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    push,
  output logic                    full,
  input  logic [HUE_BITS-1:0]     hue_i,
  input  logic [CHANNEL_BITS-1:0] saturation_i,
  input  logic [CHANNEL_BITS-1:0] brightness_i,
  input  logic                    pop,
  output logic                    empty,
  output logic [CHANNEL_BITS-1:0] red_o,
  output logic [CHANNEL_BITS-1:0] green_o,
  output logic [CHANNEL_BITS-1:0] blue_o
);

  localparam int unsigned C      = CHANNEL_BITS;
  localparam int unsigned H      = HUE_BITS;
  localparam int unsigned SW     = h2r_pkg::SECTOR_W;
  localparam int unsigned MID_W  = SW + H + 2 * C;
  localparam int unsigned OUT_W  = 3 * C;

  // front side: classified item heading into the decoupling queue
  logic                 fr_wr;
  h2r_pkg::sector_t     fr_sector;
  logic [H-1:0]         fr_frac;
  logic [C-1:0]         fr_sat;
  logic [C-1:0]         fr_val;

  // decoupling queue
  logic [MID_W-1:0]     mid_rd_data;
  logic                 mid_empty;
  logic                 mid_pop;

  // back side
  logic                 bk_ready;
  logic                 bk_push;
  logic [C-1:0]         bk_red, bk_green, bk_blue;
  logic                 out_full;
  logic [OUT_W-1:0]     out_data;

  h2r_front #(
    .CHANNEL_BITS (C),
    .HUE_BITS     (H)
  ) u_front (
    .push_i       (push),
    .queue_full_i (full),
    .hue_i        (hue_i),
    .saturation_i (saturation_i),
    .brightness_i (brightness_i),
    .wr_o         (fr_wr),
    .sector_o     (fr_sector),
    .frac_o       (fr_frac),
    .sat_o        (fr_sat),
    .val_o        (fr_val)
  );

  h2r_fifo #(
    .WIDTH (MID_W),
    .DEPTH (MID_DEPTH)
  ) u_mid_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (fr_wr),
    .data_i  ({fr_sector, fr_frac, fr_sat, fr_val}),
    .pop_i   (mid_pop),
    .data_o  (mid_rd_data),
    .full_o  (full),
    .empty_o (mid_empty)
  );

  // issue into the pipeline whenever it is moving
  assign mid_pop = !mid_empty && bk_ready;

  h2r_back #(
    .CHANNEL_BITS (C),
    .HUE_BITS     (H)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .valid_i    (mid_pop),
    .ready_o    (bk_ready),
    .sector_i   (h2r_pkg::sector_t'(mid_rd_data[MID_W-1 -: SW])),
    .frac_i     (mid_rd_data[2*C +: H]),
    .sat_i      (mid_rd_data[C +: C]),
    .val_i      (mid_rd_data[0 +: C]),
    .out_full_i (out_full),
    .push_o     (bk_push),
    .red_o      (bk_red),
    .green_o    (bk_green),
    .blue_o     (bk_blue)
  );

  // result queue parts the pipeline from the consumer
  h2r_fifo #(
    .WIDTH (OUT_W),
    .DEPTH (OUT_DEPTH)
  ) u_out_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (bk_push),
    .data_i  ({bk_red, bk_green, bk_blue}),
    .pop_i   (pop),
    .data_o  (out_data),
    .full_o  (out_full),
    .empty_o (empty)
  );

  assign red_o   = out_data[2*C +: C];
  assign green_o = out_data[C +: C];
  assign blue_o  = out_data[0 +: C];

endmodule

### src/h2r_fifo.sv
// ----------------------------------------------------------------------------
// h2r_fifo
// Small first-word-fall-through queue built from a register array.
// ----------------------------------------------------------------------------
module h2r_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 4
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] data_i,
  input  logic             pop_i,
  output logic [WIDTH-1:0] data_o,
  output logic             full_o,
  output logic             empty_o
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [AW-1:0]    wr_ptr_q, wr_ptr_d;
  logic [AW-1:0]    rd_ptr_q, rd_ptr_d;
  logic [CW-1:0]    count_q, count_d;
  logic             do_push, do_pop;

  assign full_o  = (count_q == CW'(DEPTH));
  assign empty_o = (count_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

### src/h2r_front.sv
// ----------------------------------------------------------------------------
// h2r_front
// Accepts colors and splits the hue into a sector and a fraction.
// ----------------------------------------------------------------------------
module h2r_front #(
  parameter int unsigned CHANNEL_BITS = 8,
  parameter int unsigned HUE_BITS     = 16
) (
  input  logic                    push_i,
  input  logic                    queue_full_i,
  input  logic [HUE_BITS-1:0]     hue_i,
  input  logic [CHANNEL_BITS-1:0] saturation_i,
  input  logic [CHANNEL_BITS-1:0] brightness_i,
  output logic                    wr_o,
  output h2r_pkg::sector_t        sector_o,
  output logic [HUE_BITS-1:0]     frac_o,
  output logic [CHANNEL_BITS-1:0] sat_o,
  output logic [CHANNEL_BITS-1:0] val_o
);

  // hue * 6 as a shift-add
  logic [HUE_BITS+2:0] hue_ext;
  logic [HUE_BITS+2:0] hue6;

  assign hue_ext  = {3'b000, hue_i};
  assign hue6     = (hue_ext << 2) + (hue_ext << 1);
  assign sector_o = h2r_pkg::sector_t'(hue6[HUE_BITS+2:HUE_BITS]);
  assign frac_o   = hue6[HUE_BITS-1:0];
  assign sat_o    = saturation_i;
  assign val_o    = brightness_i;
  assign wr_o     = push_i && !queue_full_i;

endmodule

### src/h2r_back.sv
// ----------------------------------------------------------------------------
// h2r_back
// Four-stage arithmetic pipeline forming p, q, t and the sector mux.
// ----------------------------------------------------------------------------
module h2r_back #(
  parameter int unsigned CHANNEL_BITS = 8,
  parameter int unsigned HUE_BITS     = 16
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    valid_i,
  output logic                    ready_o,
  input  h2r_pkg::sector_t        sector_i,
  input  logic [HUE_BITS-1:0]     frac_i,
  input  logic [CHANNEL_BITS-1:0] sat_i,
  input  logic [CHANNEL_BITS-1:0] val_i,
  input  logic                    out_full_i,
  output logic                    push_o,
  output logic [CHANNEL_BITS-1:0] red_o,
  output logic [CHANNEL_BITS-1:0] green_o,
  output logic [CHANNEL_BITS-1:0] blue_o
);

  localparam int unsigned C  = CHANNEL_BITS;
  localparam int unsigned H  = HUE_BITS;
  localparam int unsigned PW = 2 * C;

  // floor(x / (2^C - 1)) by reciprocal estimate and one correction step
  function automatic logic [C-1:0] div_cmax(input logic [PW-1:0] x);
    logic        [PW:0]   est;
    logic        [C:0]    q0;
    logic        [C:0]    qf;
    logic signed [PW+2:0] rem;
    logic signed [PW+2:0] cmax_s;
    est    = {1'b0, x} + {{(C+1){1'b0}}, x[PW-1:C]} + {{PW{1'b0}}, 1'b1};
    q0     = est[PW:C];
    rem    = signed'({3'b000, x}) - signed'({2'b00, q0, {C{1'b0}}})
             + signed'({{(C+2){1'b0}}, q0});
    cmax_s = signed'({{(C+3){1'b0}}, {C{1'b1}}});
    if (rem < 0) begin
      qf = q0 - 1'b1;
    end else if (rem >= cmax_s) begin
      qf = q0 + 1'b1;
    end else begin
      qf = q0;
    end
    return qf[C-1:0];
  endfunction

  logic advance;

  // stage 1: v*s
  logic                  s1_valid_q;
  logic [PW-1:0]         s1_vs_q;
  logic [C-1:0]          s1_v_q;
  logic [H-1:0]          s1_f_q;
  h2r_pkg::sector_t      s1_sec_q;

  // stage 2: v*s*f
  logic                  s2_valid_q;
  logic [PW+H-1:0]       s2_w_q;
  logic [PW-1:0]         s2_vs_q;
  logic [C-1:0]          s2_v_q;
  h2r_pkg::sector_t      s2_sec_q;

  // stage 3: numerators over cmax
  logic                  s3_valid_q;
  logic [PW-1:0]         s3_xp_q, s3_xq_q, s3_xt_q;
  logic [C-1:0]          s3_v_q;
  h2r_pkg::sector_t      s3_sec_q;

  // stage 4: p, q, t
  logic                  s4_valid_q;
  logic [C-1:0]          s4_p_q, s4_q_q, s4_t_q;
  logic [C-1:0]          s4_v_q;
  h2r_pkg::sector_t      s4_sec_q;

  logic [PW-1:0]         vm;
  logic [PW-1:0]         w_floor;
  logic [PW-1:0]         w_ceil;

  assign advance = !s4_valid_q || !out_full_i;
  assign ready_o = advance;
  assign push_o  = s4_valid_q && !out_full_i;

  assign vm      = {s2_v_q, {C{1'b0}}} - {{C{1'b0}}, s2_v_q};
  assign w_floor = s2_w_q[PW+H-1:H];
  assign w_ceil  = w_floor + {{(PW-1){1'b0}}, |s2_w_q[H-1:0]};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
      s3_valid_q <= 1'b0;
      s4_valid_q <= 1'b0;
    end else if (advance) begin
      s1_valid_q <= valid_i;
      s2_valid_q <= s1_valid_q;
      s3_valid_q <= s2_valid_q;
      s4_valid_q <= s3_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      s1_vs_q  <= val_i * sat_i;
      s1_v_q   <= val_i;
      s1_f_q   <= frac_i;
      s1_sec_q <= sector_i;

      s2_w_q   <= s1_vs_q * s1_f_q;
      s2_vs_q  <= s1_vs_q;
      s2_v_q   <= s1_v_q;
      s2_sec_q <= s1_sec_q;

      s3_xp_q  <= vm - s2_vs_q;
      s3_xq_q  <= vm - w_ceil;
      s3_xt_q  <= vm - s2_vs_q + w_floor;
      s3_v_q   <= s2_v_q;
      s3_sec_q <= s2_sec_q;

      s4_p_q   <= div_cmax(s3_xp_q);
      s4_q_q   <= div_cmax(s3_xq_q);
      s4_t_q   <= div_cmax(s3_xt_q);
      s4_v_q   <= s3_v_q;
      s4_sec_q <= s3_sec_q;
    end
  end

  always_comb begin
    case (s4_sec_q)
      h2r_pkg::SECTOR_RED_YELLOW: begin
        red_o = s4_v_q; green_o = s4_t_q; blue_o = s4_p_q;
      end
      h2r_pkg::SECTOR_YELLOW_GREEN: begin
        red_o = s4_q_q; green_o = s4_v_q; blue_o = s4_p_q;
      end
      h2r_pkg::SECTOR_GREEN_CYAN: begin
        red_o = s4_p_q; green_o = s4_v_q; blue_o = s4_t_q;
      end
      h2r_pkg::SECTOR_CYAN_BLUE: begin
        red_o = s4_p_q; green_o = s4_q_q; blue_o = s4_v_q;
      end
      h2r_pkg::SECTOR_BLUE_MAGENTA: begin
        red_o = s4_t_q; green_o = s4_p_q; blue_o = s4_v_q;
      end
      default: begin
        red_o = s4_v_q; green_o = s4_p_q; blue_o = s4_q_q;
      end
    endcase
  end

endmodule

### src/h2r_checker.sv
// ----------------------------------------------------------------------------
// h2r_checker
// Port-level checks for the hsv to rgb converter, bound to the top level.
// ----------------------------------------------------------------------------
module h2r_checker #(
  parameter int unsigned CHANNEL_BITS = 8
) (
  input logic                    clk_i,
  input logic                    rst_ni,
  input logic                    push,
  input logic                    full,
  input logic                    pop,
  input logic                    empty,
  input logic [CHANNEL_BITS-1:0] red_o,
  input logic [CHANNEL_BITS-1:0] green_o,
  input logic [CHANNEL_BITS-1:0] blue_o
);

  // queues are cleared while reset is held
  a_reset_clear: assert property (@(posedge clk_i)
    !rst_ni |-> (empty && !full))
    else $error("queues not clear during reset");

  // the input queue only fills after an accepted item
  a_full_after_push: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(full) |-> $past(push && !full))
    else $error("full rose without an accepted item");

  // a waiting result holds until taken
  a_result_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> (!empty && $stable(red_o) && $stable(green_o)
                          && $stable(blue_o)))
    else $error("waiting result changed or vanished");

  // results only drain on pop
  a_empty_after_pop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(empty) |-> $past(pop))
    else $error("result side emptied without pop");

endmodule

bind hsv_to_rgb_converter h2r_checker #(
  .CHANNEL_BITS (CHANNEL_BITS)
) u_h2r_checker (
  .clk_i   (clk_i),
  .rst_ni  (rst_ni),
  .push    (push),
  .full    (full),
  .pop     (pop),
  .empty   (empty),
  .red_o   (red_o),
  .green_o (green_o),
  .blue_o  (blue_o)
);

### bench/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the hsv to rgb converter: drives colors through
// the push/full side, predicts each rgb triple, and compares every popped
// item field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module testbench;

  localparam int unsigned CHAN_W = 8;
  localparam int unsigned HUE_W  = 16;

  // full scale of one channel and one full turn of hue
  localparam longint unsigned CMAX  = 255;
  localparam longint unsigned HFULL = 65536;

  // a hue step that lands just past each sector boundary
  localparam int unsigned SECTOR_STEP = 10923;

  // allow a margin after the last result for the pipeline to empty
  localparam int unsigned DRAIN_CYCLES = 24;
  localparam int unsigned CYCLE_LIMIT  = 200000;

  localparam int unsigned RANDOM_ITEMS = 1150;
  localparam int unsigned PHASES       = 4;

  typedef struct packed {
    logic [CHAN_W-1:0] red;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] blue;
  } rgb_t;

  // --------------------------------------------------------------------------
  // color ledger: predicts the rgb triple of each accepted item and keeps
  // the triples still owed by the block, oldest first
  // --------------------------------------------------------------------------
  class rgb_ledger;
    rgb_t rgb_due[$];
    int unsigned errors = 0;

    // fixed-point hsv to rgb, truncating every term toward zero
    function automatic rgb_t hsv_to_rgb(logic [HUE_W-1:0] h, logic [CHAN_W-1:0] s,
                                        logic [CHAN_W-1:0] v);
      longint unsigned hh, ss, vv, h6, frac, den, pv, qv, tv;
      h2r_pkg::sector_t sec;
      rgb_t c;
      hh = h;
      ss = s;
      vv = v;
      if (ss == 0) begin
        // grey: no hue contribution at all
        c = '{red: v, green: v, blue: v};
      end else begin
        h6   = hh * 6;
        sec  = h2r_pkg::sector_t'(h6 / HFULL);
        frac = h6 % HFULL;
        den  = CMAX * HFULL;
        pv   = (vv * (CMAX - ss)) / CMAX;
        qv   = (vv * (den - ss * frac)) / den;
        tv   = (vv * (den - ss * (HFULL - frac))) / den;
        case (sec)
          h2r_pkg::SECTOR_RED_YELLOW:
            c = '{red: vv[7:0], green: tv[7:0], blue: pv[7:0]};
          h2r_pkg::SECTOR_YELLOW_GREEN:
            c = '{red: qv[7:0], green: vv[7:0], blue: pv[7:0]};
          h2r_pkg::SECTOR_GREEN_CYAN:
            c = '{red: pv[7:0], green: vv[7:0], blue: tv[7:0]};
          h2r_pkg::SECTOR_CYAN_BLUE:
            c = '{red: pv[7:0], green: qv[7:0], blue: vv[7:0]};
          h2r_pkg::SECTOR_BLUE_MAGENTA:
            c = '{red: tv[7:0], green: pv[7:0], blue: vv[7:0]};
          default:
            c = '{red: vv[7:0], green: pv[7:0], blue: qv[7:0]};
        endcase
      end
      return c;
    endfunction

    function void note_hsv(logic [HUE_W-1:0] h, logic [CHAN_W-1:0] s,
                           logic [CHAN_W-1:0] v);
      rgb_due.push_back(hsv_to_rgb(h, s, v));
    endfunction

    function void check_rgb(logic [CHAN_W-1:0] r, logic [CHAN_W-1:0] g,
                            logic [CHAN_W-1:0] b);
      rgb_t want;
      if (rgb_due.size() == 0) begin
        $error("result item with nothing owed: red %0d green %0d blue %0d", r, g, b);
        errors++;
        return;
      end
      want = rgb_due.pop_front();
      if (r !== want.red) begin
        $error("red: expected %0d, got %0d", want.red, r);
        errors++;
      end
      if (g !== want.green) begin
        $error("green: expected %0d, got %0d", want.green, g);
        errors++;
      end
      if (b !== want.blue) begin
        $error("blue: expected %0d, got %0d", want.blue, b);
        errors++;
      end
    endfunction

    function int unsigned owed();
      return rgb_due.size();
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // block hookup
  // --------------------------------------------------------------------------
  logic              clk_i;
  logic              rst_ni;
  logic              push;
  logic              full;
  logic [HUE_W-1:0]  hue_i;
  logic [CHAN_W-1:0] saturation_i;
  logic [CHAN_W-1:0] brightness_i;
  logic              pop = 1'b0;
  logic              empty;
  logic [CHAN_W-1:0] red_o;
  logic [CHAN_W-1:0] green_o;
  logic [CHAN_W-1:0] blue_o;

  hsv_to_rgb_converter #(
    .CHANNEL_BITS (CHAN_W),
    .HUE_BITS     (HUE_W)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push         (push),
    .full         (full),
    .hue_i        (hue_i),
    .saturation_i (saturation_i),
    .brightness_i (brightness_i),
    .pop          (pop),
    .empty        (empty),
    .red_o        (red_o),
    .green_o      (green_o),
    .blue_o       (blue_o)
  );

  rgb_ledger ledger = new();

  // percent of cycles in which each side holds back
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;

  // --------------------------------------------------------------------------
  // clock
  // --------------------------------------------------------------------------
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // --------------------------------------------------------------------------
  // result side: pop changes on the falling edge, random stalls
  // --------------------------------------------------------------------------
  always @(negedge clk_i) begin
    pop <= rst_ni && ($urandom_range(99) >= recv_stall_pct);
  end

  // --------------------------------------------------------------------------
  // monitor: both handshakes sampled at the rising edge
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (push && !full) begin
        ledger.note_hsv(hue_i, saturation_i, brightness_i);
      end
      if (pop && !empty) begin
        ledger.check_rgb(red_o, green_o, blue_o);
      end
    end
  end

  // --------------------------------------------------------------------------
  // watchdog
  // --------------------------------------------------------------------------
  int unsigned cycle_count = 0;

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // input side
  // --------------------------------------------------------------------------

  // offer one item, holding it until the block takes it; called at a falling edge
  task automatic send_hsv(input logic [HUE_W-1:0] h, input logic [CHAN_W-1:0] s,
                          input logic [CHAN_W-1:0] v);
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      push <= 1'b0;
      @(negedge clk_i);
    end
    push         <= 1'b1;
    hue_i        <= h;
    saturation_i <= s;
    brightness_i <= v;
    @(posedge clk_i);
    while (full) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // channel value leaning on the extremes now and then
  function automatic logic [CHAN_W-1:0] pick_channel();
    case ($urandom_range(9))
      0:       return '0;
      1:       return '1;
      2:       return CHAN_W'($urandom_range(3));
      default: return CHAN_W'($urandom);
    endcase
  endfunction

  // hue mostly uniform, sometimes right around a sector boundary
  function automatic logic [HUE_W-1:0] pick_hue();
    int unsigned base;
    if ($urandom_range(4) == 0) begin
      base = $urandom_range(6) * SECTOR_STEP;
      return HUE_W'(base + $urandom_range(4) - 2);
    end
    return HUE_W'($urandom);
  endfunction

  // hold off until the block owes nothing
  task automatic wait_drained();
    push <= 1'b0;
    while (ledger.owed() != 0) @(negedge clk_i);
  endtask

  // --------------------------------------------------------------------------
  // stimulus
  // --------------------------------------------------------------------------
  int unsigned send_plan [PHASES] = '{0, 59, 0, 7};
  int unsigned recv_plan [PHASES] = '{0, 0, 59, 7};

  initial begin
    rst_ni       = 1'b0;
    push         = 1'b0;
    hue_i        = '0;
    saturation_i = '0;
    brightness_i = '0;
    repeat (8) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // directed: corners of every field, grey, sector edges and the hue wrap
    send_hsv(16'h0000, 8'd255, 8'd255);
    send_hsv(16'hffff, 8'd255, 8'd255);   // last hue before the wrap
    send_hsv(16'h0000, 8'd0,   8'd0);
    send_hsv(16'hffff, 8'd0,   8'd255);   // grey at full value
    send_hsv(16'h8000, 8'd0,   8'd128);   // grey, mid value
    send_hsv(16'h5555, 8'd255, 8'd0);     // black with full saturation
    send_hsv(16'd10922, 8'd255, 8'd255);  // end of first sector
    send_hsv(16'd10923, 8'd255, 8'd255);  // start of second sector
    send_hsv(16'd21845, 8'd255, 8'd255);
    send_hsv(16'd21846, 8'd255, 8'd255);
    send_hsv(16'd32768, 8'd200, 8'd255);
    send_hsv(16'd43690, 8'd255, 8'd255);
    send_hsv(16'd43691, 8'd255, 8'd255);
    send_hsv(16'd54613, 8'd255, 8'd255);
    send_hsv(16'd54614, 8'd255, 8'd255);
    // middle of every sector
    send_hsv(16'd5461,  8'd128, 8'd200);
    send_hsv(16'd16384, 8'd128, 8'd200);
    send_hsv(16'd27307, 8'd128, 8'd200);
    send_hsv(16'd38229, 8'd128, 8'd200);
    send_hsv(16'd49152, 8'd128, 8'd200);
    send_hsv(16'd60075, 8'd128, 8'd200);
    send_hsv(16'hffff, 8'd1,   8'd255);   // smallest nonzero saturation
    send_hsv(16'h0001, 8'd255, 8'd1);

    // sender stays quiet until everything is back
    wait_drained();

    // random colors across the idling phases
    for (int ph = 0; ph < PHASES; ph++) begin
      send_idle_pct  = send_plan[ph];
      recv_stall_pct = recv_plan[ph];
      for (int n = 0; n < RANDOM_ITEMS / PHASES; n++) begin
        send_hsv(pick_hue(), pick_channel(), pick_channel());
      end
      wait_drained();
    end

    // let any stray item show up before the verdict
    repeat (DRAIN_CYCLES) @(negedge clk_i);

    if (ledger.errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

### hsv_to_rgb_converter.f
src/h2r_pkg.sv
src/h2r_fifo.sv
src/h2r_front.sv
src/h2r_back.sv
src/hsv_to_rgb_converter.sv
src/h2r_checker.sv
bench/testbench.sv
